[rtl/core/sipd_pkg.sv]
// Shared types, codes and constants of the sip event detector.
// Used by every module under rtl/core; depends on nothing else.
package sipd_pkg;

    // Default widths of the streamed fields
    localparam int WEIGHT_BITS_DEF = 17;
    localparam int ACCEL_BITS_DEF  = 16;
    localparam int TIME_BITS_DEF   = 32;

    // Operation field
    localparam int OP_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_START  = 3'd0,
        OP_SAMPLE = 3'd1,
        OP_WAKE   = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_STOP   = 3'd4
    } op_t;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SIP_THR      = 3'd0,
        REG_TILT_THR     = 3'd1,
        REG_UP_AXIS      = 3'd2,
        REG_EMPTY_THR    = 3'd3,
        REG_IDLE_TIMEOUT = 3'd4,
        REG_STRAW_WIN    = 3'd5,
        REG_REFILL_PAUSE = 3'd6
    } cfg_reg_t;

    localparam int SIP_THR_W     = 14;
    localparam int TILT_THR_W    = 13;
    localparam int UP_AXIS_W     = 2;
    localparam int EMPTY_THR_W   = 16;
    localparam int IDLE_TO_W     = 32;
    localparam int STRAW_WIN_W   = 31;
    localparam int REFILL_W      = 31;
    localparam int TILT_SQ_W     = 2 * TILT_THR_W;
    localparam int STRAW_WIN3_W  = STRAW_WIN_W + 2;

    localparam logic [SIP_THR_W-1:0]    SIP_THR_RST      = 14'd150;
    localparam logic [TILT_THR_W-1:0]   TILT_THR_RST     = 13'd1024;
    localparam logic [UP_AXIS_W-1:0]    UP_AXIS_RST      = 2'd2;
    localparam logic [EMPTY_THR_W-1:0]  EMPTY_THR_RST    = 16'd150;
    localparam logic [IDLE_TO_W-1:0]    IDLE_TO_RST      = 32'd30000;
    localparam logic [STRAW_WIN_W-1:0]  STRAW_WIN_RST    = 31'd3000;
    localparam logic [REFILL_W-1:0]     REFILL_RST       = 31'd30000;
    localparam logic [TILT_SQ_W-1:0]    TILT_SQ_RST      = 26'd1048576;
    localparam logic [STRAW_WIN3_W-1:0] STRAW_WIN3_RST   = 33'd9000;

    // Up-axis codes; any other code means z is up
    localparam logic [UP_AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [UP_AXIS_W-1:0] AXIS_Y = 2'd1;

    // Live configuration seen by the datapath
    typedef struct packed {
        logic [SIP_THR_W-1:0]    sip_thr;
        logic [UP_AXIS_W-1:0]    up_axis;
        logic [EMPTY_THR_W-1:0]  empty_thr;
        logic [IDLE_TO_W-1:0]    idle_timeout;
        logic [STRAW_WIN_W-1:0]  straw_win;
        logic [STRAW_WIN3_W-1:0] straw_win3;
        logic [REFILL_W-1:0]     refill_pause;
        logic [TILT_SQ_W-1:0]    tilt_sq;
    } cfg_t;

    // Result codes
    typedef enum logic [1:0] {
        EV_NONE        = 2'd0,
        EV_PAUSE_START = 2'd1,
        EV_PAUSE_END   = 2'd2
    } refill_ev_t;

    typedef enum logic [1:0] {
        SIP_NONE  = 2'd0,
        SIP_TILT  = 2'd1,
        SIP_STRAW = 2'd2
    } sip_kind_t;

    // Result field widths
    localparam int SESS_CNT_W = 16;
    localparam int SESS_SUM_W = 24;
    localparam int LIFE_CNT_W = 32;
    localparam int LIFE_SUM_W = 32;
    localparam int SHOWN_W    = 16;

    // Detection constants, tenths of a gram
    localparam int MOTION_DG = 20;
    localparam int RISE_DG   = 50;
    localparam int GATE_DG   = 15;
    localparam int STABLE_DG = 10;

    localparam logic [1:0] STABLE_NEED = 2'd3;

endpackage

[rtl/core/sipd_cfg_regs.sv]
// Configuration register file of the sip event detector.
// Depends on sipd_pkg for register codes, widths and reset values.
module sipd_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sipd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sipd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output sipd_pkg::cfg_t                      cfg
);

    logic [sipd_pkg::SIP_THR_W-1:0]    sip_thr_reg;
    logic [sipd_pkg::TILT_THR_W-1:0]   tilt_thr_reg;
    logic [sipd_pkg::UP_AXIS_W-1:0]    up_axis_reg;
    logic [sipd_pkg::EMPTY_THR_W-1:0]  empty_thr_reg;
    logic [sipd_pkg::IDLE_TO_W-1:0]    idle_timeout_reg;
    logic [sipd_pkg::STRAW_WIN_W-1:0]  straw_win_reg;
    logic [sipd_pkg::REFILL_W-1:0]     refill_pause_reg;
    logic [sipd_pkg::TILT_SQ_W-1:0]    tilt_sq_reg;
    logic [sipd_pkg::STRAW_WIN3_W-1:0] straw_win3_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sip_thr_reg      <= sipd_pkg::SIP_THR_RST;
            tilt_thr_reg     <= sipd_pkg::TILT_THR_RST;
            up_axis_reg      <= sipd_pkg::UP_AXIS_RST;
            empty_thr_reg    <= sipd_pkg::EMPTY_THR_RST;
            idle_timeout_reg <= sipd_pkg::IDLE_TO_RST;
            straw_win_reg    <= sipd_pkg::STRAW_WIN_RST;
            refill_pause_reg <= sipd_pkg::REFILL_RST;
        end
        else if (cfg_valid)
        begin
            unique case (sipd_pkg::cfg_reg_t'(cfg_index))
                sipd_pkg::REG_SIP_THR:
                    sip_thr_reg <= cfg_data[sipd_pkg::SIP_THR_W-1:0];
                sipd_pkg::REG_TILT_THR:
                    tilt_thr_reg <= cfg_data[sipd_pkg::TILT_THR_W-1:0];
                sipd_pkg::REG_UP_AXIS:
                    up_axis_reg <= cfg_data[sipd_pkg::UP_AXIS_W-1:0];
                sipd_pkg::REG_EMPTY_THR:
                    empty_thr_reg <= cfg_data[sipd_pkg::EMPTY_THR_W-1:0];
                sipd_pkg::REG_IDLE_TIMEOUT:
                    idle_timeout_reg <= cfg_data[sipd_pkg::IDLE_TO_W-1:0];
                sipd_pkg::REG_STRAW_WIN:
                    straw_win_reg <= cfg_data[sipd_pkg::STRAW_WIN_W-1:0];
                sipd_pkg::REG_REFILL_PAUSE:
                    refill_pause_reg <= cfg_data[sipd_pkg::REFILL_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Derived values, updated in the cycle after the register they follow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_sq_reg    <= sipd_pkg::TILT_SQ_RST;
            straw_win3_reg <= sipd_pkg::STRAW_WIN3_RST;
        end
        else
        begin
            tilt_sq_reg    <= sipd_pkg::TILT_SQ_W'(tilt_thr_reg) *
                              sipd_pkg::TILT_SQ_W'(tilt_thr_reg);
            straw_win3_reg <= sipd_pkg::STRAW_WIN3_W'(straw_win_reg) +
                              sipd_pkg::STRAW_WIN3_W'({straw_win_reg, 1'b0});
        end
    end

    always_comb
    begin
        cfg.sip_thr      = sip_thr_reg;
        cfg.up_axis      = up_axis_reg;
        cfg.empty_thr    = empty_thr_reg;
        cfg.idle_timeout = idle_timeout_reg;
        cfg.straw_win    = straw_win_reg;
        cfg.straw_win3   = straw_win3_reg;
        cfg.refill_pause = refill_pause_reg;
        cfg.tilt_sq      = tilt_sq_reg;
    end

endmodule

[rtl/core/sipd_tilt.sv]
// Input register and tilt stage: captures an item, then registers the tilt
// decision beside the fields the tracker needs. Depends on sipd_pkg.
module sipd_tilt #(
    parameter int WEIGHT_BITS = sipd_pkg::WEIGHT_BITS_DEF,
    parameter int ACCEL_BITS  = sipd_pkg::ACCEL_BITS_DEF,
    parameter int TIME_BITS   = sipd_pkg::TIME_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sipd_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [sipd_pkg::OP_W-1:0]      in_op,
    input  logic signed [WEIGHT_BITS-1:0]  in_weight,
    input  logic signed [ACCEL_BITS-1:0]   in_ax,
    input  logic signed [ACCEL_BITS-1:0]   in_ay,
    input  logic signed [ACCEL_BITS-1:0]   in_az,
    input  logic [TIME_BITS-1:0]           in_now,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [sipd_pkg::OP_W-1:0]      out_op,
    output logic signed [WEIGHT_BITS-1:0]  out_weight,
    output logic [TIME_BITS-1:0]           out_now,
    output logic                           out_tilted
);

    localparam int SQ_W  = 2 * ACCEL_BITS;
    localparam int MAG_W = SQ_W + 1;
    localparam int CMP_W = (MAG_W > sipd_pkg::TILT_SQ_W) ? MAG_W : sipd_pkg::TILT_SQ_W;

    logic                          a_valid_reg;
    logic [sipd_pkg::OP_W-1:0]     a_op_reg;
    logic signed [WEIGHT_BITS-1:0] a_weight_reg;
    logic signed [ACCEL_BITS-1:0]  a_ax_reg;
    logic signed [ACCEL_BITS-1:0]  a_ay_reg;
    logic signed [ACCEL_BITS-1:0]  a_az_reg;
    logic [TIME_BITS-1:0]          a_now_reg;

    logic                          b_valid_reg;
    logic [sipd_pkg::OP_W-1:0]     b_op_reg;
    logic signed [WEIGHT_BITS-1:0] b_weight_reg;
    logic [TIME_BITS-1:0]          b_now_reg;
    logic                          b_tilted_reg;

    logic                          a_take;
    logic                          b_take;
    logic signed [ACCEL_BITS-1:0]  h1;
    logic signed [ACCEL_BITS-1:0]  h2;
    logic signed [SQ_W-1:0]        sq1;
    logic signed [SQ_W-1:0]        sq2;
    logic [MAG_W-1:0]              mag;
    logic                          tilted;

    assign b_take   = !b_valid_reg || out_ready;
    assign a_take   = !a_valid_reg || b_take;
    assign in_ready = a_take;

    // Pick the two horizontal axes
    always_comb
    begin
        case (cfg.up_axis)
            sipd_pkg::AXIS_X:
            begin
                h1 = a_ay_reg;
                h2 = a_az_reg;
            end
            sipd_pkg::AXIS_Y:
            begin
                h1 = a_ax_reg;
                h2 = a_az_reg;
            end
            default:
            begin
                h1 = a_ax_reg;
                h2 = a_ay_reg;
            end
        endcase
    end

    assign sq1    = h1 * h1;
    assign sq2    = h2 * h2;
    assign mag    = MAG_W'($unsigned(sq1)) + MAG_W'($unsigned(sq2));
    assign tilted = CMP_W'(mag) > CMP_W'(cfg.tilt_sq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_take)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_take)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take && in_valid)
        begin
            a_op_reg     <= in_op;
            a_weight_reg <= in_weight;
            a_ax_reg     <= in_ax;
            a_ay_reg     <= in_ay;
            a_az_reg     <= in_az;
            a_now_reg    <= in_now;
        end
        if (b_take && a_valid_reg)
        begin
            b_op_reg     <= a_op_reg;
            b_weight_reg <= a_weight_reg;
            b_now_reg    <= a_now_reg;
            b_tilted_reg <= tilted;
        end
    end

    assign out_valid  = b_valid_reg;
    assign out_op     = b_op_reg;
    assign out_weight = b_weight_reg;
    assign out_now    = b_now_reg;
    assign out_tilted = b_tilted_reg;

endmodule

[rtl/core/sipd_track.sv]
// Session tracker and result register: power, refill pause, tilt and straw
// sips, saturating totals. Depends on sipd_pkg.
module sipd_track #(
    parameter int WEIGHT_BITS = sipd_pkg::WEIGHT_BITS_DEF,
    parameter int TIME_BITS   = sipd_pkg::TIME_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sipd_pkg::cfg_t                       cfg,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [sipd_pkg::OP_W-1:0]            in_op,
    input  logic signed [WEIGHT_BITS-1:0]        in_weight,
    input  logic [TIME_BITS-1:0]                 in_now,
    input  logic                                 in_tilted,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 tilted,
    output logic                                 empty_res,
    output logic                                 power_low,
    output logic                                 refill_paused,
    output logic [1:0]                           refill_event,
    output logic [1:0]                           sip_kind,
    output logic [WEIGHT_BITS-1:0]               sip_amount_dg,
    output logic [sipd_pkg::SESS_CNT_W-1:0]      session_sips,
    output logic [sipd_pkg::SESS_SUM_W-1:0]      session_total_dg,
    output logic [sipd_pkg::LIFE_CNT_W-1:0]      lifetime_sips,
    output logic [sipd_pkg::LIFE_SUM_W-1:0]      lifetime_total_dg,
    output logic [sipd_pkg::SHOWN_W-1:0]         shown_weight_dg
);

    localparam int DW     = WEIGHT_BITS + 1;
    localparam int CMP_W  = (WEIGHT_BITS + 2 > 17) ? WEIGHT_BITS + 2 : 17;
    localparam int SS_W   = ((WEIGHT_BITS > sipd_pkg::SESS_SUM_W) ?
                             WEIGHT_BITS : sipd_pkg::SESS_SUM_W) + 1;
    localparam int LS_W   = ((WEIGHT_BITS > sipd_pkg::LIFE_SUM_W) ?
                             WEIGHT_BITS : sipd_pkg::LIFE_SUM_W) + 1;

    localparam logic signed [DW-1:0] MOTION_S = DW'(sipd_pkg::MOTION_DG);
    localparam logic signed [DW-1:0] RISE_S   = DW'(sipd_pkg::RISE_DG);
    localparam logic signed [DW-1:0] GATE_S   = DW'(sipd_pkg::GATE_DG);
    localparam logic signed [DW-1:0] STABLE_S = DW'(sipd_pkg::STABLE_DG);

    // State
    logic                            session_on_reg,  session_on_next;
    logic signed [WEIGHT_BITS-1:0]   prior_w_reg,     prior_w_next;
    logic signed [WEIGHT_BITS-1:0]   tilt_start_reg,  tilt_start_next;
    logic                            tilt_open_reg,   tilt_open_next;
    logic                            straw_open_reg,  straw_open_next;
    logic signed [WEIGHT_BITS-1:0]   straw_w_reg,     straw_w_next;
    logic [TIME_BITS-1:0]            straw_t_reg,     straw_t_next;
    logic                            pause_reg,       pause_next;
    logic [TIME_BITS-1:0]            pause_end_reg,   pause_end_next;
    logic [1:0]                      stable_reg,      stable_next;
    logic                            idle_reg,        idle_next;
    logic [TIME_BITS-1:0]            motion_t_reg,    motion_t_next;
    logic [sipd_pkg::SESS_CNT_W-1:0] sess_cnt_reg,    sess_cnt_next;
    logic [sipd_pkg::SESS_SUM_W-1:0] sess_sum_reg,    sess_sum_next;
    logic [WEIGHT_BITS-1:0]          last_sip_reg,    last_sip_next;
    logic [sipd_pkg::LIFE_CNT_W-1:0] life_cnt_reg,    life_cnt_next;
    logic [sipd_pkg::LIFE_SUM_W-1:0] life_sum_reg,    life_sum_next;

    // Result register
    logic                            out_valid_reg;
    logic                            out_tilted_reg,  out_tilted_next;
    logic                            out_empty_reg,   out_empty_next;
    logic [1:0]                      out_event_reg,   out_event_next;
    logic [1:0]                      out_kind_reg,    out_kind_next;
    logic [sipd_pkg::SHOWN_W-1:0]    out_shown_reg,   out_shown_next;

    logic                            take;
    logic                            is_sample;
    logic signed [DW-1:0]            delta;
    logic [DW-1:0]                   adelta;
    logic [TIME_BITS-1:0]            idle_elapsed;
    logic [TIME_BITS-1:0]            remaining;
    logic [TIME_BITS-1:0]            refill_t;
    logic [TIME_BITS-1:0]            straw_elapsed;
    logic signed [DW-1:0]            tilt_drop;
    logic signed [DW-1:0]            straw_total;
    logic                            rec;
    logic [WEIGHT_BITS-1:0]          amt;
    logic [SS_W-1:0]                 sess_sum_ext;
    logic [LS_W-1:0]                 life_sum_ext;
    logic signed [CMP_W-1:0]         pw_ext;
    logic signed [CMP_W-1:0]         sip_thr_ext;

    assign take     = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;

    assign is_sample     = (in_op == sipd_pkg::OP_SAMPLE) && session_on_reg;
    assign delta         = DW'(in_weight) - DW'(prior_w_reg);
    assign adelta        = delta[DW-1] ? DW'(-delta) : DW'(delta);
    assign idle_elapsed  = in_now - motion_t_reg;
    assign remaining     = pause_end_reg - in_now;
    assign refill_t      = TIME_BITS'(cfg.refill_pause);
    assign straw_elapsed = in_now - straw_t_reg;
    assign tilt_drop     = DW'(tilt_start_reg) - DW'(in_weight);
    assign straw_total   = DW'(straw_w_reg) - DW'(in_weight);
    assign sip_thr_ext   = $signed(CMP_W'(cfg.sip_thr));

    always_comb
    begin
        session_on_next = session_on_reg;
        prior_w_next    = prior_w_reg;
        tilt_start_next = tilt_start_reg;
        tilt_open_next  = tilt_open_reg;
        straw_open_next = straw_open_reg;
        straw_w_next    = straw_w_reg;
        straw_t_next    = straw_t_reg;
        pause_next      = pause_reg;
        pause_end_next  = pause_end_reg;
        stable_next     = stable_reg;
        idle_next       = idle_reg;
        motion_t_next   = motion_t_reg;
        sess_cnt_next   = sess_cnt_reg;
        sess_sum_next   = sess_sum_reg;
        last_sip_next   = last_sip_reg;
        life_cnt_next   = life_cnt_reg;
        life_sum_next   = life_sum_reg;
        out_tilted_next = 1'b0;
        out_event_next  = sipd_pkg::EV_NONE;
        out_kind_next   = sipd_pkg::SIP_NONE;
        rec             = 1'b0;
        amt             = '0;

        if (!is_sample)
        begin
            unique case (sipd_pkg::op_t'(in_op))
                sipd_pkg::OP_START:
                begin
                    session_on_next = 1'b1;
                    prior_w_next    = in_weight;
                    tilt_start_next = in_weight;
                    sess_cnt_next   = '0;
                    sess_sum_next   = '0;
                    last_sip_next   = '0;
                    tilt_open_next  = 1'b0;
                    motion_t_next   = in_now;
                    idle_next       = 1'b0;
                end
                sipd_pkg::OP_WAKE:
                begin
                    if (session_on_reg && idle_reg)
                    begin
                        motion_t_next = in_now;
                        idle_next     = 1'b0;
                    end
                end
                sipd_pkg::OP_CLEAR:
                begin
                    life_cnt_next = '0;
                    life_sum_next = '0;
                end
                sipd_pkg::OP_STOP:
                begin
                    session_on_next = 1'b0;
                end
                default:
                    ;
            endcase
        end
        else
        begin
            out_tilted_next = in_tilted;

            // Power tracking
            if (in_tilted || (adelta > DW'(MOTION_S)))
            begin
                motion_t_next = in_now;
                idle_next     = 1'b0;
            end
            else if (!idle_reg &&
                     (sipd_pkg::IDLE_TO_W'(idle_elapsed) > cfg.idle_timeout))
            begin
                idle_next = 1'b1;
            end

            // Refill pause: start on a sharp rise, end on stable weight or timeout
            if (!pause_reg)
            begin
                if (delta > RISE_S)
                begin
                    pause_next      = 1'b1;
                    pause_end_next  = in_now + refill_t;
                    stable_next     = '0;
                    straw_open_next = 1'b0;
                    tilt_open_next  = 1'b0;
                    out_event_next  = sipd_pkg::EV_PAUSE_START;
                end
            end
            else
            begin
                if (adelta < DW'(STABLE_S))
                begin
                    if (stable_reg < sipd_pkg::STABLE_NEED)
                    begin
                        stable_next = stable_reg + 2'd1;
                    end
                end
                else
                begin
                    stable_next = '0;
                end
                if ((stable_next >= sipd_pkg::STABLE_NEED) || (remaining == '0) ||
                    (remaining > refill_t))
                begin
                    pause_next      = 1'b0;
                    tilt_open_next  = 1'b0;
                    straw_open_next = 1'b0;
                    out_event_next  = sipd_pkg::EV_PAUSE_END;
                end
            end

            // Tilt sip: open on tilt, measure on return to upright
            if (!pause_next && in_tilted && !tilt_open_next)
            begin
                tilt_start_next = in_weight;
                tilt_open_next  = 1'b1;
            end
            if (!in_tilted && tilt_open_next)
            begin
                tilt_open_next = 1'b0;
                if (CMP_W'(tilt_drop) >= sip_thr_ext)
                begin
                    rec             = 1'b1;
                    amt             = tilt_drop[WEIGHT_BITS-1:0];
                    out_kind_next   = sipd_pkg::SIP_TILT;
                    straw_open_next = 1'b0;
                end
            end

            // Straw sip: window opened by a drop, closed by a rise or expiry
            if (!pause_next && !in_tilted)
            begin
                if (!straw_open_next)
                begin
                    if (delta < -GATE_S)
                    begin
                        straw_open_next = 1'b1;
                        straw_w_next    = prior_w_reg;
                        straw_t_next    = in_now;
                    end
                end
                else if ((delta > GATE_S) ||
                         (sipd_pkg::STRAW_WIN3_W'(straw_elapsed) > cfg.straw_win3))
                begin
                    if ((sipd_pkg::STRAW_WIN3_W'(straw_elapsed) >=
                         sipd_pkg::STRAW_WIN3_W'(cfg.straw_win)) &&
                        (CMP_W'(straw_total) >= sip_thr_ext))
                    begin
                        rec           = 1'b1;
                        amt           = straw_total[WEIGHT_BITS-1:0];
                        out_kind_next = sipd_pkg::SIP_STRAW;
                    end
                    straw_open_next = 1'b0;
                end
            end
            else
            begin
                straw_open_next = 1'b0;
            end

            prior_w_next = in_weight;
        end

        // Saturating totals
        sess_sum_ext = SS_W'(sess_sum_reg) + SS_W'(amt);
        life_sum_ext = LS_W'(life_sum_reg) + LS_W'(amt);
        if (rec)
        begin
            last_sip_next = amt;
            if (sess_cnt_reg != '1)
            begin
                sess_cnt_next = sess_cnt_reg + 1'b1;
            end
            if (life_cnt_reg != '1)
            begin
                life_cnt_next = life_cnt_reg + 1'b1;
            end
            if (sess_sum_ext > SS_W'({sipd_pkg::SESS_SUM_W{1'b1}}))
            begin
                sess_sum_next = '1;
            end
            else
            begin
                sess_sum_next = sess_sum_ext[sipd_pkg::SESS_SUM_W-1:0];
            end
            if (life_sum_ext > LS_W'({sipd_pkg::LIFE_SUM_W{1'b1}}))
            begin
                life_sum_next = '1;
            end
            else
            begin
                life_sum_next = life_sum_ext[sipd_pkg::LIFE_SUM_W-1:0];
            end
        end

        // Weight report, from the weight kept after this item
        pw_ext         = CMP_W'(prior_w_next);
        out_empty_next = pw_ext < $signed(CMP_W'(cfg.empty_thr));
        if (pw_ext[CMP_W-1])
        begin
            out_shown_next = '0;
        end
        else if (pw_ext > $signed(CMP_W'({sipd_pkg::SHOWN_W{1'b1}})))
        begin
            out_shown_next = '1;
        end
        else
        begin
            out_shown_next = pw_ext[sipd_pkg::SHOWN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            session_on_reg <= 1'b0;
            prior_w_reg    <= '0;
            tilt_start_reg <= '0;
            tilt_open_reg  <= 1'b0;
            straw_open_reg <= 1'b0;
            straw_w_reg    <= '0;
            straw_t_reg    <= '0;
            pause_reg      <= 1'b0;
            pause_end_reg  <= '0;
            stable_reg     <= '0;
            idle_reg       <= 1'b0;
            motion_t_reg   <= '0;
            sess_cnt_reg   <= '0;
            sess_sum_reg   <= '0;
            last_sip_reg   <= '0;
            life_cnt_reg   <= '0;
            life_sum_reg   <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
            if (take)
            begin
                session_on_reg <= session_on_next;
                prior_w_reg    <= prior_w_next;
                tilt_start_reg <= tilt_start_next;
                tilt_open_reg  <= tilt_open_next;
                straw_open_reg <= straw_open_next;
                straw_w_reg    <= straw_w_next;
                straw_t_reg    <= straw_t_next;
                pause_reg      <= pause_next;
                pause_end_reg  <= pause_end_next;
                stable_reg     <= stable_next;
                idle_reg       <= idle_next;
                motion_t_reg   <= motion_t_next;
                sess_cnt_reg   <= sess_cnt_next;
                sess_sum_reg   <= sess_sum_next;
                last_sip_reg   <= last_sip_next;
                life_cnt_reg   <= life_cnt_next;
                life_sum_reg   <= life_sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_tilted_reg <= out_tilted_next;
            out_empty_reg  <= out_empty_next;
            out_event_reg  <= out_event_next;
            out_kind_reg   <= out_kind_next;
            out_shown_reg  <= out_shown_next;
        end
    end

    // State only moves when a result is loaded, so it reads as that result
    assign out_valid         = out_valid_reg;
    assign tilted            = out_tilted_reg;
    assign empty_res         = out_empty_reg;
    assign power_low         = idle_reg;
    assign refill_paused     = pause_reg;
    assign refill_event      = out_event_reg;
    assign sip_kind          = out_kind_reg;
    assign sip_amount_dg     = last_sip_reg;
    assign session_sips      = sess_cnt_reg;
    assign session_total_dg  = sess_sum_reg;
    assign lifetime_sips     = life_cnt_reg;
    assign lifetime_total_dg = life_sum_reg;
    assign shown_weight_dg   = out_shown_reg;

endmodule

[rtl/core/sip_event_detector.sv]
// Top level of the sip event detector: stream ports, configuration port.
// Depends on sipd_pkg, sipd_cfg_regs, sipd_tilt and sipd_track.
//
// The block takes one item per transfer on the slave stream: a command or a
// timestamped sample (weight plus three acceleration axes), with the
// operation code in s_tuser. Every item yields exactly one result transfer
// on the master stream, carrying the flags, the sip kind (in m_tuser) and
// the session and lifetime totals. A new item is accepted every clock cycle
// when the result side keeps up; sustained rate is then one item per cycle. On
// its way from input transfer to result valid an item passes an input
// register, a register after the two squaring multipliers of the tilt test,
// and the result register that is loaded together with the session state.
// The state update of one item is combinational logic, which is what lets
// the next item follow directly. Back pressure on m_tready stalls the stages
// one by one, so empty stages keep taking input while a result waits.
// Configuration writes on the cfg channel are always taken (cfg_ready is
// tied high) and must happen only while no item is in flight; the tilt
// threshold square and three times the straw window are derived in the cycle
// after their register is written.
module sip_event_detector #(
    parameter int WEIGHT_BITS = sipd_pkg::WEIGHT_BITS_DEF,
    parameter int ACCEL_BITS  = sipd_pkg::ACCEL_BITS_DEF,
    parameter int TIME_BITS   = sipd_pkg::TIME_BITS_DEF,
    localparam int IN_W       = WEIGHT_BITS + 3 * ACCEL_BITS + TIME_BITS,
    localparam int IN_DW      = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W      = 6 + WEIGHT_BITS + sipd_pkg::SESS_CNT_W +
                                sipd_pkg::SESS_SUM_W + sipd_pkg::LIFE_CNT_W +
                                sipd_pkg::LIFE_SUM_W + sipd_pkg::SHOWN_W,
    localparam int OUT_DW     = ((OUT_W + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // weight_dg, accel_x, accel_y, accel_z, now_ms (lowest first), zero pad
    input  logic [IN_DW-1:0]                  s_tdata,
    // operation
    input  logic [sipd_pkg::OP_W-1:0]         s_tuser,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tilted, empty_res, power_low, refill_paused, refill_event,
    // sip_amount_dg, session_sips, session_total_dg, lifetime_sips,
    // lifetime_total_dg, shown_weight_dg (lowest first), zero pad
    output logic [OUT_DW-1:0]                 m_tdata,
    // sip_kind
    output logic [1:0]                        m_tuser,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sipd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sipd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AX_LSB  = WEIGHT_BITS;
    localparam int AY_LSB  = AX_LSB + ACCEL_BITS;
    localparam int AZ_LSB  = AY_LSB + ACCEL_BITS;
    localparam int NOW_LSB = AZ_LSB + ACCEL_BITS;

    sipd_pkg::cfg_t                    cfg;

    logic                              t_valid;
    logic                              t_ready;
    logic [sipd_pkg::OP_W-1:0]         t_op;
    logic signed [WEIGHT_BITS-1:0]     t_weight;
    logic [TIME_BITS-1:0]              t_now;
    logic                              t_tilted;

    logic                              tilted;
    logic                              empty_res;
    logic                              power_low;
    logic                              refill_paused;
    logic [1:0]                        refill_event;
    logic [WEIGHT_BITS-1:0]            sip_amount_dg;
    logic [sipd_pkg::SESS_CNT_W-1:0]   session_sips;
    logic [sipd_pkg::SESS_SUM_W-1:0]   session_total_dg;
    logic [sipd_pkg::LIFE_CNT_W-1:0]   lifetime_sips;
    logic [sipd_pkg::LIFE_SUM_W-1:0]   lifetime_total_dg;
    logic [sipd_pkg::SHOWN_W-1:0]      shown_weight_dg;

    sipd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Unpack the input transfer and run the tilt test
    sipd_tilt #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .ACCEL_BITS  (ACCEL_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_tilt (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_weight  ($signed(s_tdata[AX_LSB-1:0])),
        .in_ax      ($signed(s_tdata[AY_LSB-1:AX_LSB])),
        .in_ay      ($signed(s_tdata[AZ_LSB-1:AY_LSB])),
        .in_az      ($signed(s_tdata[NOW_LSB-1:AZ_LSB])),
        .in_now     (s_tdata[IN_W-1:NOW_LSB]),
        .out_valid  (t_valid),
        .out_ready  (t_ready),
        .out_op     (t_op),
        .out_weight (t_weight),
        .out_now    (t_now),
        .out_tilted (t_tilted)
    );

    // Update the session state and hold the result
    sipd_track #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_track (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .in_valid          (t_valid),
        .in_ready          (t_ready),
        .in_op             (t_op),
        .in_weight         (t_weight),
        .in_now            (t_now),
        .in_tilted         (t_tilted),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .tilted            (tilted),
        .empty_res         (empty_res),
        .power_low         (power_low),
        .refill_paused     (refill_paused),
        .refill_event      (refill_event),
        .sip_kind          (m_tuser),
        .sip_amount_dg     (sip_amount_dg),
        .session_sips      (session_sips),
        .session_total_dg  (session_total_dg),
        .lifetime_sips     (lifetime_sips),
        .lifetime_total_dg (lifetime_total_dg),
        .shown_weight_dg   (shown_weight_dg)
    );

    // Pack the result, first field in the lowest bits
    assign m_tdata = OUT_DW'({shown_weight_dg, lifetime_total_dg, lifetime_sips,
                              session_total_dg, session_sips, sip_amount_dg,
                              refill_event, refill_paused, power_low,
                              empty_res, tilted});

endmodule
